// ===== rtl/html_entity_unescape_stream_core_assert.svh =====
// Assertion macros used by the entity decoder back end.
`ifndef HTML_ENTITY_UNESCAPE_STREAM_CORE_ASSERT_SVH
`define HTML_ENTITY_UNESCAPE_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define HEU_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, held off during reset.
`define HEU_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

// ===== rtl/heu_pkg.sv =====
// Types, constants and entity name table of the entity decoder.
package heu_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] count_type;
   typedef logic [3:0][7:0] name_type;

   localparam byte_type AmpChar  = 8'h26;
   localparam byte_type SemiChar = 8'h3B;
   localparam byte_type QuotChar = 8'h22;
   localparam byte_type LtChar   = 8'h3C;
   localparam byte_type GtChar   = 8'h3E;
   localparam count_type NameMax = 3'd4;
   localparam int QueueDepth = 8;

   typedef enum logic [2:0] {
      MODE_PASS = 3'b001,
      MODE_HOLD = 3'b010,
      MODE_SKIP = 3'b100
   } mode_type;

   // One unit of work for the back end: an optional flush of the ampersand
   // and held name bytes, then an optional single tail byte.
   typedef struct packed {
      logic      flush;
      count_type count;
      name_type  held;
      logic      tail_valid;
      byte_type  tail;
      logic      text_end;
   } cmd_type;

   // Entity names, first character at index 0.
   function automatic name_type entity_text(input logic [1:0] k);
      name_type t;
      t = '0;
      case (k)
         2'd0: begin
            t[0] = 8'h61; t[1] = 8'h6D; t[2] = 8'h70;
         end
         2'd1: begin
            t[0] = 8'h71; t[1] = 8'h75; t[2] = 8'h6F; t[3] = 8'h74;
         end
         2'd2: begin
            t[0] = 8'h6C; t[1] = 8'h74;
         end
         default: begin
            t[0] = 8'h67; t[1] = 8'h74;
         end
      endcase
      return t;
   endfunction

   function automatic count_type entity_len(input logic [1:0] k);
      count_type n;
      case (k)
         2'd0:    n = 3'd3;
         2'd1:    n = 3'd4;
         default: n = 3'd2;
      endcase
      return n;
   endfunction

   function automatic byte_type entity_repl(input logic [1:0] k);
      byte_type r;
      case (k)
         2'd0:    r = AmpChar;
         2'd1:    r = QuotChar;
         2'd2:    r = LtChar;
         default: r = GtChar;
      endcase
      return r;
   endfunction

   // True if the held bytes followed by b form a prefix of some name.
   function automatic logic could_match(input count_type cnt, input name_type held,
                                        input byte_type b);
      logic any;
      logic ok;
      name_type t;
      any = 1'b0;
      for (int k = 0; k < 4; k++) begin
         t  = entity_text(k[1:0]);
         ok = (cnt < entity_len(k[1:0])) && (t[cnt[1:0]] == b);
         for (int i = 0; i < 4; i++) begin
            if (count_type'(i) < cnt && t[i] != held[i]) begin
               ok = 1'b0;
            end
         end
         any = any | ok;
      end
      return any;
   endfunction

   // Exact match of the held bytes; bit 8 flags a hit, bits 7:0 the character.
   function automatic logic [8:0] exact_match(input count_type cnt, input name_type held);
      logic [8:0] res;
      logic ok;
      name_type t;
      res = '0;
      for (int k = 3; k >= 0; k--) begin
         t  = entity_text(k[1:0]);
         ok = (entity_len(k[1:0]) == cnt);
         for (int i = 0; i < 4; i++) begin
            if (count_type'(i) < cnt && t[i] != held[i]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            res = {1'b1, entity_repl(k[1:0])};
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/heu_req_if.sv =====
// Input text channel: one byte and its final-byte flag per transfer.
interface heu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ===== rtl/heu_rsp_if.sv =====
// Output text channel: one decoded byte and its markers per transfer.
interface heu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       text_done;

   modport source (output valid, output out_byte, output run_last, output text_done,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input text_done,
                 output ready);
endinterface

// ===== rtl/html_entity_unescape_stream_core.sv =====
// Top level of the streaming HTML entity decoder.
//
//   Channel    Direction  Transfer content
//   req_port   in         data_byte, end_of_text
//   rsp_port   out        out_byte, run_last, text_done
//
// Flow: the front end takes one byte in every cycle while the command queue
// has room; each byte turns into at most one command. The back end sends one
// output byte per cycle while rsp_port is ready; a command expands to one to
// six output bytes, six for a flush of the ampersand, four held bytes and the
// current byte. A command written at an input transfer passes through a queue
// entry, the queue's head register and the back end's command register before
// its first output byte can transfer.
// Reset is synchronous and active high; it returns scanning to pass-through
// and empties the queue. A stall on rsp_port holds the back end only; the front
// end keeps taking bytes until the QUEUE_DEPTH queue entries and the queue's
// head register all hold commands.
module html_entity_unescape_stream_core #(
   parameter int QUEUE_DEPTH = heu_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   heu_req_if.sink    req_port,
   heu_rsp_if.source  rsp_port
);

   // Commands leave the front end in input order and the back end expands them
   // in the same order, so output ordering follows input ordering exactly.
   logic             push_valid;
   logic             push_ready;
   heu_pkg::cmd_type push_cmd;
   logic             pop_valid;
   logic             pop_ready;
   heu_pkg::cmd_type pop_cmd;

   // Scanner state lives in the front end: pass-through, holding a name, or
   // skipping to the semicolon after a name that cannot match.
   heu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // The queue decouples the two sides so that a long flush on the output
   // does not stop input transfers.
   heu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // The back end drives the output channel straight from its registers.
   heu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp       (rsp_port)
   );

endmodule

// ===== rtl/heu_front.sv =====
// Front end: accepts text bytes, tracks entity scanning and issues commands.
module heu_front (
   input  logic             clock,
   input  logic             reset,
   heu_req_if.sink          req,
   output logic             push_valid,
   input  logic             push_ready,
   output heu_pkg::cmd_type push_cmd
);

   heu_pkg::mode_type  mode_ff, mode_in;
   heu_pkg::count_type count_ff, count_in;
   heu_pkg::name_type  held_ff, held_in;

   logic               accept;
   logic [8:0]         hit;
   heu_pkg::cmd_type   cmd;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign hit       = heu_pkg::exact_match(count_ff, held_ff);

   always_comb begin
      mode_in        = mode_ff;
      count_in       = count_ff;
      held_in        = held_ff;
      cmd.flush      = 1'b0;
      cmd.count      = count_ff;
      cmd.held       = held_ff;
      cmd.tail_valid = 1'b0;
      cmd.tail       = req.data_byte;
      cmd.text_end   = req.end_of_text;

      case (mode_ff)
         heu_pkg::MODE_HOLD: begin
            if (req.data_byte == heu_pkg::SemiChar) begin
               cmd.tail_valid = 1'b1;
               if (hit[8]) begin
                  cmd.tail = hit[7:0];
               end else begin
                  cmd.flush = 1'b1;
               end
               count_in = '0;
               mode_in  = heu_pkg::MODE_PASS;
            end else if (count_ff < heu_pkg::NameMax &&
                         heu_pkg::could_match(count_ff, held_ff, req.data_byte)) begin
               held_in[count_ff[1:0]] = req.data_byte;
               count_in = count_ff + 3'd1;
            end else begin
               cmd.flush      = 1'b1;
               cmd.tail_valid = 1'b1;
               count_in       = '0;
               mode_in        = heu_pkg::MODE_SKIP;
            end
         end
         heu_pkg::MODE_SKIP: begin
            cmd.tail_valid = 1'b1;
            if (req.data_byte == heu_pkg::SemiChar) begin
               mode_in = heu_pkg::MODE_PASS;
            end
         end
         default: begin
            if (req.data_byte == heu_pkg::AmpChar) begin
               mode_in  = heu_pkg::MODE_HOLD;
               count_in = '0;
            end else begin
               cmd.tail_valid = 1'b1;
               mode_in        = heu_pkg::MODE_PASS;
            end
         end
      endcase

      // A final byte flushes a name that is still open.
      if (req.end_of_text) begin
         if (mode_in == heu_pkg::MODE_HOLD) begin
            cmd.flush = 1'b1;
            cmd.count = count_in;
            cmd.held  = held_in;
         end
         mode_in  = heu_pkg::MODE_PASS;
         count_in = '0;
      end
   end

   assign push_valid = accept && (cmd.flush || cmd.tail_valid);
   assign push_cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= heu_pkg::MODE_PASS;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== rtl/heu_queue.sv =====
// Command queue between the front end and the back end.
module heu_queue #(
   parameter int DEPTH = heu_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  heu_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output heu_pkg::cmd_type pop_cmd
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   heu_pkg::cmd_type entries_ff [DEPTH];
   heu_pkg::cmd_type head_ff;
   logic             head_valid_ff, head_valid_in;
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  fill_ff, fill_in;
   logic             do_push, do_pop, do_load;

   // The head register feeds the back end. It refills from the array whenever the
   // array holds a command and the head is empty or its command is being taken in this cycle.
   assign push_ready = (fill_ff != CntW'(DEPTH));
   assign pop_valid  = head_valid_ff;
   assign pop_cmd    = head_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = head_valid_ff && pop_ready;
   assign do_load    = (fill_ff != '0) && (!head_valid_ff || pop_ready);

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      head_valid_in = head_valid_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_load) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_load) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_load && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
      if (do_load) begin
         head_valid_in = 1'b1;
      end else if (do_pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         head_valid_ff <= head_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
      if (do_load) begin
         head_ff <= entries_ff[rd_ptr_ff];
      end
   end

endmodule

// ===== rtl/heu_back.sv =====
// Back end: expands each command into output bytes, one per cycle while the output channel is ready.
`include "html_entity_unescape_stream_core_assert.svh"

module heu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  heu_pkg::cmd_type pop_cmd,
   heu_rsp_if.source        rsp
);

   heu_pkg::cmd_type   cmd_ff;
   logic               cur_valid_ff, cur_valid_in;
   heu_pkg::count_type pos_ff, pos_in;

   heu_pkg::count_type n_items;
   heu_pkg::count_type held_idx;
   logic               is_last;
   logic               fire;
   logic               pop;

   // Items of a command: ampersand and held bytes when flushing, then the tail.
   assign n_items  = (cmd_ff.flush ? cmd_ff.count + 3'd1 : 3'd0) +
                     {2'b00, cmd_ff.tail_valid};
   assign held_idx = pos_ff - 3'd1;
   assign is_last  = (pos_ff == n_items - 3'd1);
   assign fire     = rsp.valid && rsp.ready;

   always_comb begin
      if (cmd_ff.flush && pos_ff == 3'd0) begin
         rsp.out_byte = heu_pkg::AmpChar;
      end else if (cmd_ff.flush && pos_ff <= cmd_ff.count) begin
         rsp.out_byte = cmd_ff.held[held_idx[1:0]];
      end else begin
         rsp.out_byte = cmd_ff.tail;
      end
   end

   assign rsp.valid     = cur_valid_ff;
   assign rsp.run_last  = is_last;
   assign rsp.text_done = is_last && cmd_ff.text_end;

   assign pop_ready = !cur_valid_ff || (fire && is_last);
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         pos_in       = '0;
      end else if (fire && is_last) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= pop_cmd;
      end
   end

   `HEU_ASSERT_IMPLY(a_pos_in_range, clock, reset, cur_valid_ff, pos_ff < n_items, "item position beyond command length")
   `HEU_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, pop_cmd.flush || pop_cmd.tail_valid, "empty command taken from queue")
   `HEU_ASSERT_NEXT(a_pos_advance, clock, reset, fire && !is_last, cur_valid_ff && pos_ff == $past(pos_ff) + 3'd1, "command did not advance by one item")
   `HEU_ASSERT_IMPLY(a_done_is_last, clock, reset, cur_valid_ff && rsp.text_done, rsp.run_last, "end of text not on last item of a command")

endmodule
